FILE: rtl/core/tsq_pkg.sv
// Shared constants, types and helper functions of the touch sample qualifier.
// Depends on nothing; compile first.
package tsq_pkg;

   localparam int RAW_BITS      = 12;
   localparam int SCREEN_BITS   = 11;
   localparam int TOP_BITS      = SCREEN_BITS - 1;
   localparam int NUM_BITS      = RAW_BITS + TOP_BITS;
   localparam int DIV_STEPS     = TOP_BITS;
   localparam int CNT_BITS      = $clog2(DIV_STEPS);
   localparam int TIME_BITS     = 32;
   localparam int ORIENT_BITS   = 3;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 2 * RAW_BITS;

   localparam int SAMPLE_INTERVAL_MS = 25;
   localparam int DEBOUNCE_MS        = 40;
   localparam int LONG_PRESS_MS      = 700;
   localparam int MIN_PRESSURE       = 1;
   localparam int MAX_SCREEN         = 2 ** TOP_BITS;

   // orientation flag bit positions
   localparam int ORIENT_SWAP  = 0;
   localparam int ORIENT_INV_X = 1;
   localparam int ORIENT_INV_Y = 2;

   localparam logic [RAW_BITS-1:0]      RST_CAL_MIN    = RAW_BITS'(200);
   localparam logic [RAW_BITS-1:0]      RST_CAL_MAX    = RAW_BITS'(3900);
   localparam logic [SCREEN_BITS-1:0]   RST_WIDTH      = SCREEN_BITS'(320);
   localparam logic [SCREEN_BITS-1:0]   RST_HEIGHT     = SCREEN_BITS'(240);
   localparam logic [ORIENT_BITS-1:0]   RST_ORIENT     = '0;
   localparam logic [CSR_DATA_BITS-1:0] RST_IDLE_POINT = '0;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CAL_MIN_X,
      CSR_CAL_MAX_X,
      CSR_CAL_MIN_Y,
      CSR_CAL_MAX_Y,
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT,
      CSR_ORIENTATION,
      CSR_IDLE_POINT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } tsq_state_type;

   // Largest screen coordinate: size - 1, with size 0 read as 1 and sizes
   // above the maximum read as the maximum.
   function automatic logic [TOP_BITS-1:0] clamp_top(input logic [SCREEN_BITS-1:0] size);
      logic [TOP_BITS-1:0] top;
      if (size == '0) begin
         top = '0;
      end else if (size > SCREEN_BITS'(MAX_SCREEN)) begin
         top = '1;
      end else begin
         top = TOP_BITS'(size - SCREEN_BITS'(1));
      end
      return top;
   endfunction

endpackage

FILE: rtl/core/tsq_if.sv
// Handshake channels of the touch sample qualifier: sample in, result out, register write.
// Depends on tsq_pkg.
interface tsq_req_if;
   logic                               valid;
   logic                               ready;
   logic [tsq_pkg::TIME_BITS-1:0]      now_ms;
   logic [tsq_pkg::RAW_BITS-1:0]       sample_x;
   logic [tsq_pkg::RAW_BITS-1:0]       sample_y;
   logic [tsq_pkg::RAW_BITS-1:0]       sample_z;
   logic                               irq_level_active;

   modport source (output valid, now_ms, sample_x, sample_y, sample_z, irq_level_active,
                   input ready);
   modport sink   (input valid, now_ms, sample_x, sample_y, sample_z, irq_level_active,
                   output ready);
endinterface

interface tsq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 is_pressed;
   logic                                 is_long_pressed;
   logic [tsq_pkg::RAW_BITS-1:0]         out_raw_x;
   logic [tsq_pkg::RAW_BITS-1:0]         out_raw_y;
   logic [tsq_pkg::RAW_BITS-1:0]         out_raw_z;
   logic signed [tsq_pkg::SCREEN_BITS-1:0] pos_x;
   logic signed [tsq_pkg::SCREEN_BITS-1:0] pos_y;
   logic                                 irq_seen;
   logic                                 state_changed;

   modport source (output valid, is_pressed, is_long_pressed, out_raw_x, out_raw_y,
                          out_raw_z, pos_x, pos_y, irq_seen, state_changed,
                   input ready);
   modport sink   (input valid, is_pressed, is_long_pressed, out_raw_x, out_raw_y,
                         out_raw_z, pos_x, pos_y, irq_seen, state_changed,
                   output ready);
endinterface

interface tsq_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tsq_pkg::CSR_IDX_BITS-1:0]    index;
   logic [tsq_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/touch_sample_qualifier.sv
// Touch sample qualifier: rate limit, validity check, calibrated mapping and debounce.
// Depends on tsq_pkg and the channel interfaces in tsq_if.sv.
//
// A rate-limited or invalid sample goes from req through EVAL straight to OUT; a mapped
// one also passes MUL for each axis, and DIV when the value lies strictly inside the
// window (one shared restoring divider, one quotient bit per cycle, 10 steps per axis).
// A new sample is taken only once the last is done: req is ready again the cycle after the
// result is loaded into the rsp register, which then waits for its own transfer.
// Reset (synchronous, active high) restores the register defaults and clears all
// debounce and held state; the rsp register comes up empty. csr writes are always taken.
module touch_sample_qualifier (
   input  logic      clock,
   input  logic      reset,
   tsq_req_if.sink   req_ch,
   tsq_rsp_if.source rsp_ch,
   tsq_csr_if.sink   csr_ch
);

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [tsq_pkg::RAW_BITS-1:0]      cal_min_x_ff, cal_max_x_ff, cal_min_y_ff, cal_max_y_ff;
   logic [tsq_pkg::SCREEN_BITS-1:0]   width_ff, height_ff;
   logic [tsq_pkg::ORIENT_BITS-1:0]   orient_ff;
   logic [tsq_pkg::CSR_DATA_BITS-1:0] idle_point_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_min_x_ff  <= tsq_pkg::RST_CAL_MIN;
         cal_max_x_ff  <= tsq_pkg::RST_CAL_MAX;
         cal_min_y_ff  <= tsq_pkg::RST_CAL_MIN;
         cal_max_y_ff  <= tsq_pkg::RST_CAL_MAX;
         width_ff      <= tsq_pkg::RST_WIDTH;
         height_ff     <= tsq_pkg::RST_HEIGHT;
         orient_ff     <= tsq_pkg::RST_ORIENT;
         idle_point_ff <= tsq_pkg::RST_IDLE_POINT;
      end else if (csr_ch.valid) begin
         // truncate the write data to each register's width
         case (tsq_pkg::csr_index_type'(csr_ch.index))
            tsq_pkg::CSR_CAL_MIN_X:     cal_min_x_ff  <= csr_ch.data[tsq_pkg::RAW_BITS-1:0];
            tsq_pkg::CSR_CAL_MAX_X:     cal_max_x_ff  <= csr_ch.data[tsq_pkg::RAW_BITS-1:0];
            tsq_pkg::CSR_CAL_MIN_Y:     cal_min_y_ff  <= csr_ch.data[tsq_pkg::RAW_BITS-1:0];
            tsq_pkg::CSR_CAL_MAX_Y:     cal_max_y_ff  <= csr_ch.data[tsq_pkg::RAW_BITS-1:0];
            tsq_pkg::CSR_SCREEN_WIDTH:  width_ff      <= csr_ch.data[tsq_pkg::SCREEN_BITS-1:0];
            tsq_pkg::CSR_SCREEN_HEIGHT: height_ff     <= csr_ch.data[tsq_pkg::SCREEN_BITS-1:0];
            tsq_pkg::CSR_ORIENTATION:   orient_ff     <= csr_ch.data[tsq_pkg::ORIENT_BITS-1:0];
            tsq_pkg::CSR_IDLE_POINT:    idle_point_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencer, held state and work registers
   // ---------------------------------------------------------------------------------
   tsq_pkg::tsq_state_type state_ff, state_in;

   // debounce and held result state
   logic [tsq_pkg::TIME_BITS-1:0]     last_ff, last_in;
   logic                              cand_lvl_ff, cand_lvl_in;
   logic [tsq_pkg::TIME_BITS-1:0]     cand_time_ff, cand_time_in;
   logic [tsq_pkg::TIME_BITS-1:0]     pst_ff, pst_in;
   logic                              held_pressed_ff, held_pressed_in;
   logic                              held_long_ff, held_long_in;
   logic [tsq_pkg::RAW_BITS-1:0]      held_rx_ff, held_rx_in;
   logic [tsq_pkg::RAW_BITS-1:0]      held_ry_ff, held_ry_in;
   logic [tsq_pkg::RAW_BITS-1:0]      held_rz_ff, held_rz_in;
   logic [tsq_pkg::SCREEN_BITS-1:0]   held_sx_ff, held_sx_in;
   logic [tsq_pkg::SCREEN_BITS-1:0]   held_sy_ff, held_sy_in;
   logic                              held_irq_ff, held_irq_in;
   logic                              axis_ff, axis_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // captured sample and per-item work values
   logic [tsq_pkg::TIME_BITS-1:0]     now_ff, now_in;
   logic [tsq_pkg::RAW_BITS-1:0]      rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic                              irq_ff, irq_in;
   logic                              skip_ff, skip_in;
   logic                              valid_ff, valid_in;
   logic                              deb_ff, deb_in;
   logic                              lng_ff, lng_in;
   logic [tsq_pkg::CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [tsq_pkg::NUM_BITS-1:0]      div_ff, div_in;
   logic [tsq_pkg::RAW_BITS-1:0]      den_ff, den_in;
   logic [tsq_pkg::TOP_BITS-1:0]      qx_ff, qx_in, qy_ff, qy_in;

   // rsp payload register
   logic                              o_pressed_ff, o_pressed_in;
   logic                              o_long_ff, o_long_in;
   logic [tsq_pkg::RAW_BITS-1:0]      o_rx_ff, o_rx_in, o_ry_ff, o_ry_in, o_rz_ff, o_rz_in;
   logic [tsq_pkg::SCREEN_BITS-1:0]   o_sx_ff, o_sx_in, o_sy_ff, o_sy_in;
   logic                              o_irq_ff, o_irq_in;
   logic                              o_chg_ff, o_chg_in;

   // ---------------------------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------------------------
   logic [tsq_pkg::TOP_BITS-1:0]  wtop, htop;
   logic [tsq_pkg::TIME_BITS-1:0] since_last, since_cand, since_press;
   logic                          sample_ok, cand_flip, settle_ok, deb_new, start_new;
   logic                          swap;
   logic [tsq_pkg::RAW_BITS-1:0]  ax_v, ax_lo, ax_hi;
   logic [tsq_pkg::TOP_BITS-1:0]  ax_top;
   logic [tsq_pkg::RAW_BITS+1:0]  trial;
   logic                          trial_ge;
   logic [tsq_pkg::NUM_BITS-1:0]  div_step;
   logic [tsq_pkg::TOP_BITS-1:0]  fx, fy;
   logic [tsq_pkg::SCREEN_BITS-1:0] new_sx, new_sy;
   logic                          changed;
   logic                          axis_done;
   logic [tsq_pkg::TOP_BITS-1:0]  q_result;
   logic                          rsp_load;

   assign wtop = tsq_pkg::clamp_top(width_ff);
   assign htop = tsq_pkg::clamp_top(height_ff);

   // wrapping time differences, all modulo 2^32
   assign since_last  = now_ff - last_ff;
   assign since_cand  = now_ff - cand_time_ff;
   assign since_press = now_ff - pst_ff;

   // a sample counts when it is off the idle point, pressed, and inside both windows
   assign sample_ok = !(rx_ff == idle_point_ff[tsq_pkg::RAW_BITS-1:0] &&
                        ry_ff == idle_point_ff[tsq_pkg::CSR_DATA_BITS-1:tsq_pkg::RAW_BITS]) &&
                      rz_ff >= tsq_pkg::RAW_BITS'(tsq_pkg::MIN_PRESSURE) &&
                      rx_ff >= cal_min_x_ff && rx_ff <= cal_max_x_ff &&
                      ry_ff >= cal_min_y_ff && ry_ff <= cal_max_y_ff;

   // a level change restarts the debounce window at zero elapsed time
   assign cand_flip = sample_ok != cand_lvl_ff;
   assign settle_ok = !cand_flip && since_cand >= tsq_pkg::TIME_BITS'(tsq_pkg::DEBOUNCE_MS);
   assign deb_new   = (sample_ok == held_pressed_ff || settle_ok) ? sample_ok : held_pressed_ff;
   assign start_new = deb_new && !held_pressed_ff;

   // axis operands for the shared scaler; a swap feeds each window the other raw value
   assign swap   = orient_ff[tsq_pkg::ORIENT_SWAP];
   assign ax_v   = (axis_ff ^ swap) ? ry_ff : rx_ff;
   assign ax_lo  = axis_ff ? cal_min_y_ff : cal_min_x_ff;
   assign ax_hi  = axis_ff ? cal_max_y_ff : cal_max_x_ff;
   assign ax_top = axis_ff ? htop : wtop;

   // one restoring division step: partial remainder in the upper bits, quotient in the lower
   assign trial    = {1'b0, div_ff[tsq_pkg::NUM_BITS-1:tsq_pkg::TOP_BITS],
                      div_ff[tsq_pkg::TOP_BITS-1]} - {2'b00, den_ff};
   assign trial_ge = !trial[tsq_pkg::RAW_BITS+1];
   assign div_step = trial_ge ?
                     {trial[tsq_pkg::RAW_BITS-1:0], div_ff[tsq_pkg::TOP_BITS-2:0], 1'b1} :
                     {div_ff[tsq_pkg::NUM_BITS-2:0], 1'b0};

   // final screen position, with inversion; -1 whenever not both pressed and mapped
   assign fx     = orient_ff[tsq_pkg::ORIENT_INV_X] ? (wtop - qx_ff) : qx_ff;
   assign fy     = orient_ff[tsq_pkg::ORIENT_INV_Y] ? (htop - qy_ff) : qy_ff;
   assign new_sx = (deb_ff && valid_ff) ? {1'b0, fx} : '1;
   assign new_sy = (deb_ff && valid_ff) ? {1'b0, fy} : '1;

   assign changed = deb_ff != held_pressed_ff || lng_ff != held_long_ff ||
                    rx_ff != held_rx_ff || ry_ff != held_ry_ff || rz_ff != held_rz_ff ||
                    new_sx != held_sx_ff || new_sy != held_sy_ff || irq_ff != held_irq_ff;

   assign rsp_load     = (state_ff == tsq_pkg::ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = (state_ff == tsq_pkg::ST_IDLE);

   // ---------------------------------------------------------------------------------
   // Next state and next values
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      last_in         = last_ff;
      cand_lvl_in     = cand_lvl_ff;
      cand_time_in    = cand_time_ff;
      pst_in          = pst_ff;
      held_pressed_in = held_pressed_ff;
      held_long_in    = held_long_ff;
      held_rx_in      = held_rx_ff;
      held_ry_in      = held_ry_ff;
      held_rz_in      = held_rz_ff;
      held_sx_in      = held_sx_ff;
      held_sy_in      = held_sy_ff;
      held_irq_in     = held_irq_ff;
      axis_in         = axis_ff;
      now_in          = now_ff;
      rx_in           = rx_ff;
      ry_in           = ry_ff;
      rz_in           = rz_ff;
      irq_in          = irq_ff;
      skip_in         = skip_ff;
      valid_in        = valid_ff;
      deb_in          = deb_ff;
      lng_in          = lng_ff;
      cnt_in          = cnt_ff;
      div_in          = div_ff;
      den_in          = den_ff;
      qx_in           = qx_ff;
      qy_in           = qy_ff;
      o_pressed_in    = o_pressed_ff;
      o_long_in       = o_long_ff;
      o_rx_in         = o_rx_ff;
      o_ry_in         = o_ry_ff;
      o_rz_in         = o_rz_ff;
      o_sx_in         = o_sx_ff;
      o_sy_in         = o_sy_ff;
      o_irq_in        = o_irq_ff;
      o_chg_in        = o_chg_ff;
      axis_done       = 1'b0;
      q_result        = '0;
      // drop the rsp valid once its transfer completes
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         tsq_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               now_in   = req_ch.now_ms;
               rx_in    = req_ch.sample_x;
               ry_in    = req_ch.sample_y;
               rz_in    = req_ch.sample_z;
               irq_in   = req_ch.irq_level_active;
               state_in = tsq_pkg::ST_EVAL;
            end
         end

         tsq_pkg::ST_EVAL: begin
            if (since_last < tsq_pkg::TIME_BITS'(tsq_pkg::SAMPLE_INTERVAL_MS)) begin
               // too soon: repeat the held state, touch nothing
               skip_in  = 1'b1;
               state_in = tsq_pkg::ST_OUT;
            end else begin
               skip_in  = 1'b0;
               last_in  = now_ff;
               valid_in = sample_ok;
               if (cand_flip) begin
                  cand_lvl_in  = sample_ok;
                  cand_time_in = now_ff;
               end
               if (start_new) begin
                  pst_in = now_ff;
               end
               deb_in = deb_new;
               // a fresh press has zero hold time, so it cannot be long yet
               lng_in = deb_new && !start_new &&
                        since_press >= tsq_pkg::TIME_BITS'(tsq_pkg::LONG_PRESS_MS);
               axis_in  = 1'b0;
               state_in = sample_ok ? tsq_pkg::ST_MUL : tsq_pkg::ST_OUT;
            end
         end

         tsq_pkg::ST_MUL: begin
            // settle the clamp cases up front; only a value strictly inside the window
            // needs the divider, and then its quotient stays below the top coordinate
            if (ax_lo == ax_hi || ax_v <= ax_lo) begin
               axis_done = 1'b1;
               q_result  = '0;
            end else if (ax_v >= ax_hi) begin
               axis_done = 1'b1;
               q_result  = ax_top;
            end else begin
               div_in   = tsq_pkg::NUM_BITS'(ax_v - ax_lo) * tsq_pkg::NUM_BITS'(ax_top);
               den_in   = ax_hi - ax_lo;
               cnt_in   = '0;
               state_in = tsq_pkg::ST_DIV;
            end
         end

         tsq_pkg::ST_DIV: begin
            div_in = div_step;
            cnt_in = cnt_ff + tsq_pkg::CNT_BITS'(1);
            if (cnt_ff == tsq_pkg::CNT_BITS'(tsq_pkg::DIV_STEPS - 1)) begin
               axis_done = 1'b1;
               q_result  = div_step[tsq_pkg::TOP_BITS-1:0];
            end
         end

         tsq_pkg::ST_OUT: begin
            // hold here until the rsp register is free
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = tsq_pkg::ST_IDLE;
               if (skip_ff) begin
                  o_pressed_in = held_pressed_ff;
                  o_long_in    = held_long_ff;
                  o_rx_in      = held_rx_ff;
                  o_ry_in      = held_ry_ff;
                  o_rz_in      = held_rz_ff;
                  o_sx_in      = held_sx_ff;
                  o_sy_in      = held_sy_ff;
                  o_irq_in     = held_irq_ff;
                  o_chg_in     = 1'b0;
               end else begin
                  o_pressed_in    = deb_ff;
                  o_long_in       = lng_ff;
                  o_rx_in         = rx_ff;
                  o_ry_in         = ry_ff;
                  o_rz_in         = rz_ff;
                  o_sx_in         = new_sx;
                  o_sy_in         = new_sy;
                  o_irq_in        = irq_ff;
                  o_chg_in        = changed;
                  held_pressed_in = deb_ff;
                  held_long_in    = lng_ff;
                  held_rx_in      = rx_ff;
                  held_ry_in      = ry_ff;
                  held_rz_in      = rz_ff;
                  held_sx_in      = new_sx;
                  held_sy_in      = new_sy;
                  held_irq_in     = irq_ff;
               end
            end
         end

         default: begin
            state_in = tsq_pkg::ST_IDLE;
         end
      endcase

      // store a finished axis and advance to the next one or to the output
      if (axis_done) begin
         if (!axis_ff) begin
            qx_in    = q_result;
            axis_in  = 1'b1;
            state_in = tsq_pkg::ST_MUL;
         end else begin
            qy_in    = q_result;
            state_in = tsq_pkg::ST_OUT;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tsq_pkg::ST_IDLE;
         last_ff         <= '0;
         cand_lvl_ff     <= 1'b0;
         cand_time_ff    <= '0;
         pst_ff          <= '0;
         held_pressed_ff <= 1'b0;
         held_long_ff    <= 1'b0;
         held_rx_ff      <= '0;
         held_ry_ff      <= '0;
         held_rz_ff      <= '0;
         held_sx_ff      <= '0;
         held_sy_ff      <= '0;
         held_irq_ff     <= 1'b0;
         axis_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         last_ff         <= last_in;
         cand_lvl_ff     <= cand_lvl_in;
         cand_time_ff    <= cand_time_in;
         pst_ff          <= pst_in;
         held_pressed_ff <= held_pressed_in;
         held_long_ff    <= held_long_in;
         held_rx_ff      <= held_rx_in;
         held_ry_ff      <= held_ry_in;
         held_rz_ff      <= held_rz_in;
         held_sx_ff      <= held_sx_in;
         held_sy_ff      <= held_sy_in;
         held_irq_ff     <= held_irq_in;
         axis_ff         <= axis_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rz_ff        <= rz_in;
      irq_ff       <= irq_in;
      skip_ff      <= skip_in;
      valid_ff     <= valid_in;
      deb_ff       <= deb_in;
      lng_ff       <= lng_in;
      cnt_ff       <= cnt_in;
      div_ff       <= div_in;
      den_ff       <= den_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      o_pressed_ff <= o_pressed_in;
      o_long_ff    <= o_long_in;
      o_rx_ff      <= o_rx_in;
      o_ry_ff      <= o_ry_in;
      o_rz_ff      <= o_rz_in;
      o_sx_ff      <= o_sx_in;
      o_sy_ff      <= o_sy_in;
      o_irq_ff     <= o_irq_in;
      o_chg_ff     <= o_chg_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.is_pressed      = o_pressed_ff;
   assign rsp_ch.is_long_pressed = o_long_ff;
   assign rsp_ch.out_raw_x       = o_rx_ff;
   assign rsp_ch.out_raw_y       = o_ry_ff;
   assign rsp_ch.out_raw_z       = o_rz_ff;
   assign rsp_ch.pos_x           = o_sx_ff;
   assign rsp_ch.pos_y           = o_sy_ff;
   assign rsp_ch.irq_seen        = o_irq_ff;
   assign rsp_ch.state_changed   = o_chg_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   a_long_implies_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.is_pressed || !rsp_ch.is_long_pressed))
      else $error("long press reported without a press");

   a_req_starts_eval: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == tsq_pkg::ST_EVAL && !req_ch.ready))
      else $error("req transfer did not start the evaluation");

   a_div_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsq_pkg::ST_DIV) |-> (cnt_ff < tsq_pkg::CNT_BITS'(tsq_pkg::DIV_STEPS)))
      else $error("divider step count out of range");

   a_quotient_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsq_pkg::ST_OUT && !skip_ff && valid_ff) |-> (qx_ff <= wtop && qy_ff <= htop))
      else $error("scaled coordinate beyond screen edge");

endmodule

FILE: sim/tb_touch_sample_qualifier.sv
`timescale 1ns / 100ps
// Self-checking testbench of touch_sample_qualifier: random touch gestures and noise
// against a cycle-free predictor. Depends on tsq_pkg, tsq_if.sv and the block itself.
module tb_touch_sample_qualifier;

   localparam int ITEMS_PER_PHASE = 98;
   localparam int NUM_SETTINGS    = 8;
   localparam int DRAIN_CYCLES    = 30;
   localparam int WATCHDOG_LIMIT  = 4000;

   typedef struct packed {
      logic [tsq_pkg::TIME_BITS-1:0] now_ms;
      logic [tsq_pkg::RAW_BITS-1:0]  x;
      logic [tsq_pkg::RAW_BITS-1:0]  y;
      logic [tsq_pkg::RAW_BITS-1:0]  z;
      logic                          irq;
   } touch_sample_type;

   typedef struct packed {
      logic                                   pressed;
      logic                                   long_press;
      logic [tsq_pkg::RAW_BITS-1:0]           raw_x;
      logic [tsq_pkg::RAW_BITS-1:0]           raw_y;
      logic [tsq_pkg::RAW_BITS-1:0]           raw_z;
      logic signed [tsq_pkg::SCREEN_BITS-1:0] pos_x;
      logic signed [tsq_pkg::SCREEN_BITS-1:0] pos_y;
      logic                                   irq;
      logic                                   changed;
   } touch_report_type;

   logic clock;
   logic reset;

   tsq_req_if req_bus ();
   tsq_rsp_if rsp_bus ();
   tsq_csr_if csr_bus ();

   touch_sample_qualifier u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Calibration registers as the predictor sees them.
   logic [tsq_pkg::RAW_BITS-1:0]    cal_min_x, cal_max_x, cal_min_y, cal_max_y;
   logic [tsq_pkg::SCREEN_BITS-1:0] scr_width, scr_height;
   logic [tsq_pkg::ORIENT_BITS-1:0] orient;
   logic [2*tsq_pkg::RAW_BITS-1:0]  idle_xy;

   // Debounce and held state of the predictor.
   logic [tsq_pkg::TIME_BITS-1:0] last_accept_ms;
   logic                          cand_level;
   logic [tsq_pkg::TIME_BITS-1:0] cand_ms;
   logic [tsq_pkg::TIME_BITS-1:0] press_start_ms;
   touch_report_type              held_report;

   touch_sample_type sample_queue[$];       // samples waiting for the driver
   touch_report_type expected_reports[$];   // predicted reports, oldest first
   touch_sample_type driven_sample;

   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int samples_pushed;
   int samples_accepted;
   int reports_checked;
   int idle_cycles;
   logic [tsq_pkg::TIME_BITS-1:0] sim_ms;   // running millisecond clock of the gestures

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Largest coordinate of an axis: zero size counts as one, oversize as 1024.
   function automatic int axis_top(input logic [tsq_pkg::SCREEN_BITS-1:0] size);
      if (size == '0) return 0;
      if (size > tsq_pkg::SCREEN_BITS'(tsq_pkg::MAX_SCREEN)) return tsq_pkg::MAX_SCREEN - 1;
      return int'(size) - 1;
   endfunction

   // Linear map with truncating signed division, then clamp to 0..top.
   function automatic int scale_coord(input logic [tsq_pkg::RAW_BITS-1:0] v,
                                      input logic [tsq_pkg::RAW_BITS-1:0] lo,
                                      input logic [tsq_pkg::RAW_BITS-1:0] hi,
                                      input int top);
      longint nv, nlo, nhi, num, den, q;
      nv  = v;
      nlo = lo;
      nhi = hi;
      num = (nv - nlo) * longint'(top);
      den = nhi - nlo;
      q   = (den == 0) ? 0 : num / den;
      if (q < 0) q = 0;
      if (q > top) q = top;
      return int'(q);
   endfunction

   function automatic void reset_predictor();
      cal_min_x      = tsq_pkg::RST_CAL_MIN;
      cal_max_x      = tsq_pkg::RST_CAL_MAX;
      cal_min_y      = tsq_pkg::RST_CAL_MIN;
      cal_max_y      = tsq_pkg::RST_CAL_MAX;
      scr_width      = tsq_pkg::RST_WIDTH;
      scr_height     = tsq_pkg::RST_HEIGHT;
      orient         = tsq_pkg::RST_ORIENT;
      idle_xy        = tsq_pkg::RST_IDLE_POINT;
      last_accept_ms = '0;
      cand_level     = 1'b0;
      cand_ms        = '0;
      press_start_ms = '0;
      held_report    = '0;
   endfunction

   // Work out the report for one accepted sample and advance the held state.
   function automatic touch_report_type qualify_sample(input touch_sample_type s);
      touch_report_type              nr;
      logic [tsq_pkg::TIME_BITS-1:0] since_accept;
      logic [tsq_pkg::TIME_BITS-1:0] since_cand;
      logic [tsq_pkg::TIME_BITS-1:0] since_press;
      logic [tsq_pkg::RAW_BITS-1:0]  mx, my;
      logic                          valid, deb, lng;
      int                            wtop, htop, sx, sy;

      since_accept = s.now_ms - last_accept_ms;
      if (since_accept < tsq_pkg::TIME_BITS'(tsq_pkg::SAMPLE_INTERVAL_MS)) begin
         nr         = held_report;
         nr.changed = 1'b0;
         return nr;
      end
      last_accept_ms = s.now_ms;

      if (s.x == idle_xy[tsq_pkg::RAW_BITS-1:0] &&
          s.y == idle_xy[2*tsq_pkg::RAW_BITS-1:tsq_pkg::RAW_BITS]) begin
         valid = 1'b0;
      end else begin
         valid = s.z >= tsq_pkg::RAW_BITS'(tsq_pkg::MIN_PRESSURE) &&
                 s.x >= cal_min_x && s.x <= cal_max_x &&
                 s.y >= cal_min_y && s.y <= cal_max_y;
      end

      sx = -1;
      sy = -1;
      if (valid) begin
         wtop = axis_top(scr_width);
         htop = axis_top(scr_height);
         mx   = orient[tsq_pkg::ORIENT_SWAP] ? s.y : s.x;
         my   = orient[tsq_pkg::ORIENT_SWAP] ? s.x : s.y;
         sx   = scale_coord(mx, cal_min_x, cal_max_x, wtop);
         sy   = scale_coord(my, cal_min_y, cal_max_y, htop);
         if (orient[tsq_pkg::ORIENT_INV_X]) sx = wtop - sx;
         if (orient[tsq_pkg::ORIENT_INV_Y]) sy = htop - sy;
      end

      if (valid != cand_level) begin
         cand_level = valid;
         cand_ms    = s.now_ms;
      end
      since_cand = s.now_ms - cand_ms;
      if (valid == held_report.pressed ||
          since_cand >= tsq_pkg::TIME_BITS'(tsq_pkg::DEBOUNCE_MS)) begin
         deb = valid;
      end else begin
         deb = held_report.pressed;
      end

      if (deb && !held_report.pressed) press_start_ms = s.now_ms;
      since_press = s.now_ms - press_start_ms;
      lng = deb && since_press >= tsq_pkg::TIME_BITS'(tsq_pkg::LONG_PRESS_MS);
      if (!deb) begin
         sx  = -1;
         sy  = -1;
         lng = 1'b0;
      end

      nr.pressed    = deb;
      nr.long_press = lng;
      nr.raw_x      = s.x;
      nr.raw_y      = s.y;
      nr.raw_z      = s.z;
      nr.pos_x      = tsq_pkg::SCREEN_BITS'(sx);
      nr.pos_y      = tsq_pkg::SCREEN_BITS'(sy);
      nr.irq        = s.irq;
      nr.changed    = 1'b0;
      // held_report always keeps changed low, so this compares the reported fields
      nr.changed    = (nr != held_report);

      held_report         = nr;
      held_report.changed = 1'b0;
      return nr;
   endfunction

   // -------------------------------------------------------------------------
   // Sample driver: hold valid until the transfer, predict on every transfer
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_reports.push_back(qualify_sample(driven_sample));
            samples_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (sample_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               driven_sample             = sample_queue.pop_front();
               req_bus.valid            <= 1'b1;
               req_bus.now_ms           <= driven_sample.now_ms;
               req_bus.sample_x         <= driven_sample.x;
               req_bus.sample_y         <= driven_sample.y;
               req_bus.sample_z         <= driven_sample.z;
               req_bus.irq_level_active <= driven_sample.irq;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Report monitor: compare each transfer with the oldest prediction
   // -------------------------------------------------------------------------
   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : report_monitor
      touch_report_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_reports.size() == 0) begin
               error_count++;
               $display("%0t: unexpected report, expected none, got raw %0d/%0d/%0d",
                        $time, rsp_bus.out_raw_x, rsp_bus.out_raw_y, rsp_bus.out_raw_z);
            end else begin
               want = expected_reports.pop_front();
               check_field("is_pressed",      want.pressed,    rsp_bus.is_pressed);
               check_field("is_long_pressed", want.long_press, rsp_bus.is_long_pressed);
               check_field("out_raw_x",       want.raw_x,      rsp_bus.out_raw_x);
               check_field("out_raw_y",       want.raw_y,      rsp_bus.out_raw_y);
               check_field("out_raw_z",       want.raw_z,      rsp_bus.out_raw_z);
               check_field("pos_x",           want.pos_x,      rsp_bus.pos_x);
               check_field("pos_y",           want.pos_y,      rsp_bus.pos_y);
               check_field("irq_seen",        want.irq,        rsp_bus.irq_seen);
               check_field("state_changed",   want.changed,    rsp_bus.state_changed);
               reports_checked++;
            end
         end
         rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: count cycles in which no channel moves a transfer
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic push_sample(input logic [tsq_pkg::TIME_BITS-1:0] t, input int x,
                              input int y, input int z, input logic irq);
      touch_sample_type s;
      s.now_ms = t;
      s.x      = tsq_pkg::RAW_BITS'(x);
      s.y      = tsq_pkg::RAW_BITS'(y);
      s.z      = tsq_pkg::RAW_BITS'(z);
      s.irq    = irq;
      sample_queue.push_back(s);
      samples_pushed++;
   endtask

   // Write one register; the predictor takes the value at the transfer.
   task automatic write_reg(input tsq_pkg::csr_index_type idx,
                            input logic [tsq_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         tsq_pkg::CSR_CAL_MIN_X:     cal_min_x  = value[tsq_pkg::RAW_BITS-1:0];
         tsq_pkg::CSR_CAL_MAX_X:     cal_max_x  = value[tsq_pkg::RAW_BITS-1:0];
         tsq_pkg::CSR_CAL_MIN_Y:     cal_min_y  = value[tsq_pkg::RAW_BITS-1:0];
         tsq_pkg::CSR_CAL_MAX_Y:     cal_max_y  = value[tsq_pkg::RAW_BITS-1:0];
         tsq_pkg::CSR_SCREEN_WIDTH:  scr_width  = value[tsq_pkg::SCREEN_BITS-1:0];
         tsq_pkg::CSR_SCREEN_HEIGHT: scr_height = value[tsq_pkg::SCREEN_BITS-1:0];
         tsq_pkg::CSR_ORIENTATION:   orient     = value[tsq_pkg::ORIENT_BITS-1:0];
         tsq_pkg::CSR_IDLE_POINT:    idle_xy    = value;
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   // Register setting of each phase; phase 0 runs on the reset values.
   task automatic apply_setting(input int phase);
      logic [tsq_pkg::CSR_DATA_BITS-1:0] vals [NUM_SETTINGS];
      int a, b;
      case (phase)
         1: vals = '{0, 4095, 0, 4095, 1024, 1024, 0, 24'hFF_FFFF};
         2: vals = '{100, 4000, 300, 3000, 2047, 0, 7, {12'd1500, 12'd1200}};
         3: vals = '{2048, 2048, 1000, 3000, 1, 2, 1, 0};
         4: vals = '{3000, 1000, 200, 3900, 800, 600, 6, {12'd100, 12'd100}};
         5: begin
            a = $urandom_range(4095, 0);
            b = $urandom_range(4095, 0);
            vals[0] = (a < b) ? a : b;
            vals[1] = (a < b) ? b : a;
            a = $urandom_range(4095, 0);
            b = $urandom_range(4095, 0);
            vals[2] = (a < b) ? a : b;
            vals[3] = (a < b) ? b : a;
            vals[4] = $urandom_range(2047, 0);
            vals[5] = $urandom_range(2047, 0);
            vals[6] = $urandom_range(7, 0);
            vals[7] = tsq_pkg::CSR_DATA_BITS'($urandom());
         end
         6: vals = '{0, 1000, 2000, 4095, 640, 480, 1, {12'd3000, 12'd500}};
         default: vals = '{200, 3900, 200, 3900, 320, 240, 2, {12'd2000, 12'd2000}};
      endcase
      for (int i = 0; i < NUM_SETTINGS; i++) write_reg(tsq_pkg::csr_index_type'(i), vals[i]);
   endtask

   // Advance the gesture clock: mostly the normal poll period, some too-early
   // polls that get rate limited, a few long pauses.
   task automatic advance_ms();
      int r;
      r = $urandom_range(99, 0);
      if (r < 15)      sim_ms += $urandom_range(24, 0);
      else if (r < 90) sim_ms += $urandom_range(50, 25);
      else             sim_ms += $urandom_range(1500, 51);
   endtask

   // A finger on the panel inside the calibration window, now and then at the idle reading.
   task automatic push_touch();
      int x, y, z;
      x = $urandom_range(cal_max_x, cal_min_x);
      y = $urandom_range(cal_max_y, cal_min_y);
      z = ($urandom_range(9, 0) == 0) ? 1 : $urandom_range(4095, 1);
      if ($urandom_range(19, 0) == 0) begin
         x = idle_xy[tsq_pkg::RAW_BITS-1:0];
         y = idle_xy[2*tsq_pkg::RAW_BITS-1:tsq_pkg::RAW_BITS];
      end
      push_sample(sim_ms, x, y, z, $urandom_range(9, 0) != 0);
   endtask

   // No finger: zero pressure, the idle reading or a coordinate off the window.
   task automatic push_release();
      int x, y, z;
      x = $urandom_range(4095, 0);
      y = $urandom_range(4095, 0);
      z = $urandom_range(4095, 0);
      case ($urandom_range(2, 0))
         0: z = 0;
         1: begin
            x = idle_xy[tsq_pkg::RAW_BITS-1:0];
            y = idle_xy[2*tsq_pkg::RAW_BITS-1:tsq_pkg::RAW_BITS];
         end
         default: begin
            if (cal_min_x > 0)         x = $urandom_range(cal_min_x - 1, 0);
            else if (cal_max_x < 4095) x = $urandom_range(4095, cal_max_x + 1);
            else                       z = 0;
         end
      endcase
      push_sample(sim_ms, x, y, z, $urandom_range(9, 0) == 0);
   endtask

   // One press-and-release with the odd glitch in the middle of the press.
   task automatic push_gesture();
      int hold_len, rel_len;
      hold_len = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
      rel_len  = $urandom_range(5, 1);
      for (int i = 0; i < hold_len; i++) begin
         advance_ms();
         if ($urandom_range(99, 0) < 8) push_release();
         else                           push_touch();
      end
      for (int i = 0; i < rel_len; i++) begin
         advance_ms();
         push_release();
      end
   endtask

   task automatic push_random_phase();
      int start;
      start = samples_pushed;
      if ($urandom_range(3, 0) == 0) sim_ms = 32'hFFFF_FFFF - $urandom_range(2000, 0);
      while (samples_pushed - start < ITEMS_PER_PHASE) begin
         if ($urandom_range(99, 0) < 88) begin
            push_gesture();
         end else begin
            repeat ($urandom_range(4, 1)) begin
               sim_ms = $urandom();
               push_sample(sim_ms, $urandom_range(4095, 0), $urandom_range(4095, 0),
                           $urandom_range(4095, 0), $urandom_range(1, 0));
            end
         end
      end
   endtask

   // Wait until every sample is taken and every report checked, then let the
   // block settle before the registers change.
   task automatic drain();
      while (sample_queue.size() != 0 || req_bus.valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      // hold every input at a known value until the first edge
      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.now_ms           = '0;
      req_bus.sample_x         = '0;
      req_bus.sample_y         = '0;
      req_bus.sample_z         = '0;
      req_bus.irq_level_active = 1'b0;
      rsp_bus.ready            = 1'b0;
      csr_bus.valid            = 1'b0;
      csr_bus.index            = tsq_pkg::CSR_CAL_MIN_X;
      csr_bus.data             = '0;
      send_idle_pct            = 0;
      recv_stall_pct           = 0;
      error_count              = 0;
      samples_pushed           = 0;
      samples_accepted         = 0;
      reports_checked          = 0;
      idle_cycles              = 0;
      sim_ms                   = '0;
      reset_predictor();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset calibration.
      // First poll at time zero falls inside the rate limit: reset state, position 0.
      push_sample(32'd0, 2000, 2000, 100, 1'b1);
      // window corners, the low one at minimum pressure; the first high corner poll is too early
      push_sample(32'd30, 200, 200, 1, 1'b1);
      push_sample(32'd50, 3900, 3900, 4095, 1'b1);
      push_sample(32'd75, 3900, 3900, 4095, 1'b1);
      // release being debounced: still pressed but unmapped, then the idle reading
      push_sample(32'd110, 199, 2000, 500, 1'b1);
      push_sample(32'd140, 0, 0, 4095, 1'b0);
      push_sample(32'd170, 2000, 3901, 50, 1'b0);
      push_sample(32'd200, 2000, 2000, 0, 1'b1);
      // press held long enough to be flagged long
      for (int t = 230; t <= 1030; t += 100) push_sample(t, 1000 + t, 3000 - t / 2, 800, 1'b1);
      // identical poll: nothing changes
      push_sample(32'd1060, 2030, 2485, 800, 1'b1);
      // release across the wrap of the millisecond counter
      push_sample(32'hFFFF_FFF0, 4095, 4095, 4095, 1'b0);
      push_sample(32'h0000_0018, 4095, 4095, 4095, 1'b0);
      push_sample(32'h0000_0030, 4095, 4095, 4095, 1'b0);
      sim_ms = 32'h0000_0100;

      for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
         if (phase != 0) apply_setting(phase);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         push_random_phase();
         drain();
      end

      $display("Drove %0d touch samples through %0d calibration settings, %0d reports checked,",
               samples_accepted, NUM_SETTINGS, reports_checked);
      $display("%0d field mismatches.", error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/tsq_pkg.sv
rtl/core/tsq_if.sv
rtl/core/touch_sample_qualifier.sv
sim/tb_touch_sample_qualifier.sv
